@@ hw/rtl/vp9_frame_header_parser_assert.svh @@
// assertion macros for the vp9 frame header parser
// expects clk and rst in scope at the point of use
`ifndef VP9_FRAME_HEADER_PARSER_ASSERT_SVH
`define VP9_FRAME_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define VP9FH_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vp9 header parser check failed");

// next-cycle implication
`define VP9FH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vp9 header parser check failed");

`endif

@@ hw/rtl/vp9fh_pkg.sv @@
// types, constants and the per-bit parse step of the vp9 frame header parser
// no dependencies
package vp9fh_pkg;

  localparam logic [7:0] SYNC_BYTE_0 = 8'h49;
  localparam logic [7:0] SYNC_BYTE_1 = 8'h83;
  localparam logic [7:0] SYNC_BYTE_2 = 8'h42;
  localparam logic [1:0] MARKER_CODE = 2'd2;

  localparam logic [2:0] MTX_UNSPEC   = 3'd0;
  localparam logic [2:0] MTX_BT470BG  = 3'd1;
  localparam logic [2:0] MTX_IDENTITY = 3'd6;

  localparam logic [3:0] DEPTH_8  = 4'd8;
  localparam logic [3:0] DEPTH_10 = 4'd10;
  localparam logic [3:0] DEPTH_12 = 4'd12;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  typedef struct packed {
    logic        header_valid;
    logic [1:0]  profile;
    logic [3:0]  sample_depth;
    logic        is_key;
    logic        sub_x;
    logic        sub_y;
    logic [2:0]  matrix_kind;
    logic        full_range;
    logic [16:0] frame_width;
    logic [16:0] frame_height;
  } header_beat_t;

  typedef enum logic [20:0] {
    PH_MARKER      = 21'h000001,
    PH_PROF_LO     = 21'h000002,
    PH_PROF_HI     = 21'h000004,
    PH_RESERVED    = 21'h000008,
    PH_SHOW_EXIST  = 21'h000010,
    PH_FRAME_TYPE  = 21'h000020,
    PH_SHOW        = 21'h000040,
    PH_ERR_RES     = 21'h000080,
    PH_INTRA_ONLY  = 21'h000100,
    PH_RESET_CTX   = 21'h000200,
    PH_SYNC        = 21'h000400,
    PH_TWELVE      = 21'h000800,
    PH_MATRIX      = 21'h001000,
    PH_RANGE       = 21'h002000,
    PH_SUBX        = 21'h004000,
    PH_SUBY        = 21'h008000,
    PH_CC_RESERVED = 21'h010000,
    PH_REFRESH     = 21'h020000,
    PH_WIDTH       = 21'h040000,
    PH_HEIGHT      = 21'h080000,
    PH_DONE        = 21'h100000
  } phase_t;

  typedef struct packed {
    logic [3:0] depth;
    logic [2:0] matrix;
    logic       range;
    logic       sx;
    logic       sy;
  } colour_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  cnt;
    logic [15:0] acc;
    logic [1:0]  profile;
    logic        key;
    logic        show;
    logic        err;
    colour_t     colour;
    logic [15:0] width;
    logic [15:0] height;
    logic        reject;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase: PH_MARKER, cnt: 5'd0, acc: 16'd0, profile: 2'd0, key: 1'b0, show: 1'b0,
    err: 1'b0, colour: '0, width: 16'd0, height: 16'd0, reject: 1'b0
  };

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    return SYNC_BYTE_0;
      2'd1:    return SYNC_BYTE_1;
      2'd2:    return SYNC_BYTE_2;
      default: return 8'h00;
    endcase
  endfunction

  // reserved code 6 folds to unspecified, code 7 is identity
  function automatic logic [2:0] matrix_map(input logic [2:0] code);
    case (code)
      3'd6:    return MTX_UNSPEC;
      3'd7:    return MTX_IDENTITY;
      default: return code;
    endcase
  endfunction

  function automatic colour_t make_colour(input logic [3:0] depth, input logic [2:0] matrix,
                                         input logic range, input logic sx, input logic sy);
    colour_t c;
    c.depth  = depth;
    c.matrix = matrix;
    c.range  = range;
    c.sx     = sx;
    c.sy     = sy;
    return c;
  endfunction

  // one header bit through the parser
  function automatic parse_state_t parse_bit(input parse_state_t s, input logic b);
    parse_state_t n;
    logic [15:0]  acc_n;
    logic [7:0]   acc8;
    logic [4:0]   cnt_n;
    logic         odd;
    logic [2:0]   m;
    n     = s;
    acc_n = {s.acc[14:0], b};
    acc8  = {s.acc[6:0], b};
    cnt_n = s.cnt + 5'd1;
    odd   = s.profile[0];
    m     = matrix_map(acc_n[2:0]);
    case (s.phase)
      PH_MARKER: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd2) begin
          if (acc_n != {14'd0, MARKER_CODE}) n.reject = 1'b1;
          n.acc   = 16'd0;
          n.cnt   = 5'd0;
          n.phase = PH_PROF_LO;
        end
      end
      PH_PROF_LO: begin
        n.profile[0] = b;
        n.phase      = PH_PROF_HI;
      end
      PH_PROF_HI: begin
        n.profile[1] = b;
        n.phase      = (s.profile[0] && b) ? PH_RESERVED : PH_SHOW_EXIST;
      end
      PH_RESERVED: begin
        if (b) n.reject = 1'b1;
        n.phase = PH_SHOW_EXIST;
      end
      PH_SHOW_EXIST: begin
        if (b) n.reject = 1'b1;
        n.phase = PH_FRAME_TYPE;
      end
      PH_FRAME_TYPE: begin
        if (!b) n.key = 1'b1;
        n.phase = PH_SHOW;
      end
      PH_SHOW: begin
        if (b) n.show = 1'b1;
        n.phase = PH_ERR_RES;
      end
      PH_ERR_RES: begin
        if (b) n.err = 1'b1;
        if (s.key) begin
          n.phase = PH_SYNC;
        end else begin
          if (s.show) n.reject = 1'b1;
          n.phase = PH_INTRA_ONLY;
        end
      end
      PH_INTRA_ONLY: begin
        if (!b) n.reject = 1'b1;
        n.phase = s.err ? PH_SYNC : PH_RESET_CTX;
      end
      PH_RESET_CTX: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd2) begin
          n.acc   = 16'd0;
          n.cnt   = 5'd0;
          n.phase = PH_SYNC;
        end
      end
      PH_SYNC: begin
        n.acc = {8'd0, acc8};
        n.cnt = cnt_n;
        // check each sync byte as it completes
        if (cnt_n[2:0] == 3'd0) begin
          if (acc8 != sync_byte(cnt_n[4:3] - 2'd1)) n.reject = 1'b1;
          n.acc = 16'd0;
        end
        if (cnt_n >= 5'd24) begin
          n.cnt = 5'd0;
          if (s.key || s.profile != 2'd0) begin
            n.colour = make_colour(DEPTH_8, MTX_UNSPEC, 1'b0, 1'b0, 1'b0);
            n.phase  = s.profile[1] ? PH_TWELVE : PH_MATRIX;
          end else begin
            // intra-only profile 0 has an implied color config
            n.colour = make_colour(DEPTH_8, MTX_BT470BG, 1'b0, 1'b1, 1'b1);
            n.phase  = PH_REFRESH;
          end
        end
      end
      PH_TWELVE: begin
        n.colour = make_colour(b ? DEPTH_12 : DEPTH_10, MTX_UNSPEC, 1'b0, 1'b0, 1'b0);
        n.phase  = PH_MATRIX;
      end
      PH_MATRIX: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd3) begin
          n.acc = 16'd0;
          n.cnt = 5'd0;
          if (m == MTX_IDENTITY) begin
            n.colour = make_colour(s.colour.depth, MTX_IDENTITY, 1'b1, 1'b0, 1'b0);
            if (odd) n.phase = PH_CC_RESERVED;
            else     n.phase = s.key ? PH_WIDTH : PH_REFRESH;
          end else begin
            n.colour = make_colour(s.colour.depth, m, 1'b0, 1'b0, 1'b0);
            n.phase  = PH_RANGE;
          end
        end
      end
      PH_RANGE: begin
        n.colour.range = b;
        if (odd) begin
          n.phase = PH_SUBX;
        end else begin
          n.colour.sx = 1'b1;
          n.colour.sy = 1'b1;
          n.phase     = s.key ? PH_WIDTH : PH_REFRESH;
        end
      end
      PH_SUBX: begin
        n.colour.sx = b;
        n.phase     = PH_SUBY;
      end
      PH_SUBY: begin
        n.colour.sy = b;
        n.phase     = PH_CC_RESERVED;
      end
      PH_CC_RESERVED: begin
        n.phase = s.key ? PH_WIDTH : PH_REFRESH;
      end
      PH_REFRESH: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd8) begin
          n.acc   = 16'd0;
          n.cnt   = 5'd0;
          n.phase = PH_WIDTH;
        end
      end
      PH_WIDTH: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd16) begin
          n.width = acc_n;
          n.acc   = 16'd0;
          n.cnt   = 5'd0;
          n.phase = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        n.acc = acc_n;
        n.cnt = cnt_n;
        if (cnt_n >= 5'd16) begin
          n.height = acc_n;
          n.acc    = 16'd0;
          n.cnt    = 5'd0;
          n.phase  = PH_DONE;
        end
      end
      default: begin
        n = s;
      end
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/vp9fh_parse_core.sv @@
// parse state register and the eight-bit parse step for one byte
// depends on vp9fh_pkg
module vp9fh_parse_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  vp9fh_pkg::frame_beat_t beat,
  output vp9fh_pkg::header_beat_t result
);
  import vp9fh_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  parse_state_t walk;
  logic         ok;

  // bits go msb first; parsing stops once rejected or done
  always_comb begin
    walk = st;
    for (int i = 7; i >= 0; i--) begin
      if (!walk.reject && walk.phase != PH_DONE) begin
        walk = parse_bit(walk, beat.frame_byte[3'(i)]);
      end
    end
  end

  assign ok = !walk.reject && walk.phase == PH_DONE;

  always_comb begin
    result = '0;
    if (ok) begin
      result.header_valid = 1'b1;
      result.profile      = walk.profile;
      result.sample_depth = walk.colour.depth;
      result.is_key       = walk.key;
      result.sub_x        = walk.colour.sx;
      result.sub_y        = walk.colour.sy;
      result.matrix_kind  = walk.colour.matrix;
      result.full_range   = walk.colour.range;
      result.frame_width  = {1'b0, walk.width} + 17'd1;
      result.frame_height = {1'b0, walk.height} + 17'd1;
    end
  end

  // the last byte of a frame sends the parser back to its start
  assign st_next = beat.last_byte ? PARSE_RESET : walk;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

@@ hw/rtl/vp9_frame_header_parser.sv @@
// vp9 uncompressed frame header parser, top level
// depends on vp9fh_pkg, vp9fh_parse_core and vp9_frame_header_parser_assert.svh
//
//  channel | direction | payload        | beat
//  frame   | in        | frame_beat_t   | one coded byte, last-byte mark
//  hdr     | out       | header_beat_t  | one header result per frame
//
// one byte per cycle while no last byte is held by a stalled result: the byte register
// feeds the eight-bit parse step, whose state updates in the same cycle; hdr_valid and
// the result are registered as a frame's last byte leaves the byte register.
// the parse step is the longest path.
// rst (synchronous) empties both registers and returns the parser to the marker.
// a stalled result holds only a last byte in the byte register; other bytes flow.
module vp9_frame_header_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    frame_valid,
  output logic                    frame_stall,
  input  vp9fh_pkg::frame_beat_t  frame_data,
  output logic                    hdr_valid,
  input  logic                    hdr_stall,
  output vp9fh_pkg::header_beat_t hdr_data
);
  import vp9fh_pkg::*;

  `include "vp9_frame_header_parser_assert.svh"

  logic         in_full;
  frame_beat_t  in_beat;
  logic         advance;
  logic         load;
  header_beat_t core_result;

  // a last byte needs room in the result register
  assign advance     = in_full && (!in_beat.last_byte || !hdr_valid || !hdr_stall);
  assign load        = advance && in_beat.last_byte;
  assign frame_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= frame_stall ? 1'b1 : frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      in_beat <= frame_data;
    end
  end

  vp9fh_parse_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .beat   (in_beat),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (load) begin
      hdr_valid <= 1'b1;
    end else if (!hdr_stall) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_data <= core_result;
    end
  end

  `VP9FH_ASSERT_NEXT(a_load_shows, load, hdr_valid)
  `VP9FH_ASSERT_NOW(a_stall_only_last, frame_stall, in_beat.last_byte && hdr_valid && hdr_stall)
  `VP9FH_ASSERT_NOW(a_reject_zero, hdr_valid && !hdr_data.header_valid,
                    hdr_data.frame_width == 17'd0 && hdr_data.sample_depth == 4'd0)
  `VP9FH_ASSERT_NOW(a_depth_legal, hdr_valid && hdr_data.header_valid,
                    hdr_data.sample_depth == DEPTH_8 || hdr_data.sample_depth == DEPTH_10 ||
                    hdr_data.sample_depth == DEPTH_12)

endmodule

@@ tb/tb_vp9_frame_header_parser.sv @@
// testbench for vp9_frame_header_parser: byte-serial frames in, one header result per frame out
// depends on vp9fh_pkg and the parser rtl; self-checking against a bit-serial predictor
`timescale 1ns / 1ps

module tb_vp9_frame_header_parser;
  import vp9fh_pkg::*;

  localparam int RANDOM_BYTES = 1750;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_AT_BYTE = 500;

  // raw 3-bit matrix codes with special handling
  localparam logic [2:0] CODE_MTX_RESERVED = 3'd6;
  localparam logic [2:0] CODE_MTX_IDENTITY = 3'd7;

  typedef enum logic [1:0] {CHK_PRED, CHK_REJECT, CHK_FULL} row_check_t;

  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
    row_check_t chk;
  } dir_row_t;

  typedef struct {
    phase_t      ph;
    int unsigned nbits;
    logic [15:0] acc;
    logic [1:0]  prof;
    bit          key;
    bit          shown;
    bit          err_res;
    logic [3:0]  depth;
    logic [2:0]  mtx;
    bit          rng;
    bit          sx;
    bit          sy;
    logic [15:0] w;
    logic [15:0] h;
    bit          rejected;
  } parse_track_t;

  localparam header_beat_t HDR_REJECT = '0;
  localparam header_beat_t HDR_FULL = '{header_valid: 1'b1, profile: 2'd0, sample_depth: DEPTH_8,
                                        is_key: 1'b1, sub_x: 1'b0, sub_y: 1'b0,
                                        matrix_kind: MTX_IDENTITY, full_range: 1'b1,
                                        frame_width: 17'h10000, frame_height: 17'h10000};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         frame_valid = 1'b0;
  logic         frame_stall;
  frame_beat_t  frame_data = '0;
  logic         hdr_valid;
  logic         hdr_stall = 1'b0;
  header_beat_t hdr_data;

  vp9_frame_header_parser dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_data  (frame_data),
    .hdr_valid   (hdr_valid),
    .hdr_stall   (hdr_stall),
    .hdr_data    (hdr_data)
  );

  always #5 clk = ~clk;

  parse_track_t trk;
  header_beat_t headers_due[$];
  bit           hdr_bits[$];
  logic [7:0]   frame_bytes[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           gaps_on = 1'b0;
  bit           hold_req = 1'b0;

  // directed frames: quick rejects, bad sync, a header cut short, a max-size keyframe
  dir_row_t dir_rows [22] = '{
    '{8'h00, 1'b1, CHK_REJECT},
    '{8'hFF, 1'b1, CHK_REJECT},
    '{8'h88, 1'b1, CHK_REJECT},
    '{8'h8C, 1'b1, CHK_REJECT},
    '{8'hB8, 1'b1, CHK_REJECT},
    '{8'h82, 1'b0, CHK_PRED}, '{8'h49, 1'b0, CHK_PRED}, '{8'h00, 1'b1, CHK_REJECT},
    '{8'h82, 1'b0, CHK_PRED}, '{8'h49, 1'b0, CHK_PRED}, '{8'h83, 1'b0, CHK_PRED},
    '{8'h42, 1'b0, CHK_PRED}, '{8'h12, 1'b1, CHK_REJECT},
    '{8'h82, 1'b0, CHK_PRED}, '{8'h49, 1'b0, CHK_PRED}, '{8'h83, 1'b0, CHK_PRED},
    '{8'h42, 1'b0, CHK_PRED}, '{8'hFF, 1'b0, CHK_PRED}, '{8'hFF, 1'b0, CHK_PRED},
    '{8'hFF, 1'b0, CHK_PRED}, '{8'hFF, 1'b0, CHK_PRED}, '{8'hE0, 1'b1, CHK_FULL}
  };

  function automatic void clear_track();
    trk.ph       = PH_MARKER;
    trk.nbits    = 0;
    trk.acc      = '0;
    trk.prof     = '0;
    trk.key      = 1'b0;
    trk.shown    = 1'b0;
    trk.err_res  = 1'b0;
    trk.depth    = '0;
    trk.mtx      = '0;
    trk.rng      = 1'b0;
    trk.sx       = 1'b0;
    trk.sy       = 1'b0;
    trk.w        = '0;
    trk.h        = '0;
    trk.rejected = 1'b0;
  endfunction

  // shift one bit into the current field, true once n bits are in
  function automatic bit collect(input bit b, input int unsigned n, output logic [15:0] v);
    trk.acc = {trk.acc[14:0], b};
    trk.nbits++;
    v = trk.acc;
    if (trk.nbits >= n) begin
      trk.acc   = '0;
      trk.nbits = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void colour_done();
    trk.ph = trk.key ? PH_WIDTH : PH_REFRESH;
  endfunction

  function automatic void parse_header_bit(input bit b);
    logic [15:0] v;
    logic [7:0]  want;
    bit          odd;
    odd = trk.prof[0];
    case (trk.ph)
      PH_MARKER: begin
        if (collect(b, 2, v)) begin
          if (v != {14'd0, MARKER_CODE}) trk.rejected = 1'b1;
          trk.ph = PH_PROF_LO;
        end
      end
      PH_PROF_LO: begin
        trk.prof[0] = b;
        trk.ph      = PH_PROF_HI;
      end
      PH_PROF_HI: begin
        trk.prof[1] = b;
        trk.ph      = (trk.prof == 2'd3) ? PH_RESERVED : PH_SHOW_EXIST;
      end
      PH_RESERVED: begin
        if (b) trk.rejected = 1'b1;
        trk.ph = PH_SHOW_EXIST;
      end
      PH_SHOW_EXIST: begin
        if (b) trk.rejected = 1'b1;
        trk.ph = PH_FRAME_TYPE;
      end
      PH_FRAME_TYPE: begin
        trk.key = !b;
        trk.ph  = PH_SHOW;
      end
      PH_SHOW: begin
        trk.shown = b;
        trk.ph    = PH_ERR_RES;
      end
      PH_ERR_RES: begin
        trk.err_res = b;
        if (trk.key) begin
          trk.ph = PH_SYNC;
        end else begin
          if (trk.shown) trk.rejected = 1'b1;
          trk.ph = PH_INTRA_ONLY;
        end
      end
      PH_INTRA_ONLY: begin
        if (!b) trk.rejected = 1'b1;
        trk.ph = trk.err_res ? PH_SYNC : PH_RESET_CTX;
      end
      PH_RESET_CTX: begin
        if (collect(b, 2, v)) trk.ph = PH_SYNC;
      end
      PH_SYNC: begin
        trk.acc = {8'd0, trk.acc[6:0], b};
        trk.nbits++;
        if (trk.nbits % 8 == 0) begin
          case (trk.nbits / 8)
            1:       want = SYNC_BYTE_0;
            2:       want = SYNC_BYTE_1;
            default: want = SYNC_BYTE_2;
          endcase
          if (trk.acc[7:0] != want) trk.rejected = 1'b1;
          trk.acc = '0;
        end
        if (trk.nbits == 24) begin
          trk.nbits = 0;
          trk.rng   = 1'b0;
          if (trk.key || trk.prof != 2'd0) begin
            trk.depth = DEPTH_8;
            trk.mtx   = MTX_UNSPEC;
            trk.sx    = 1'b0;
            trk.sy    = 1'b0;
            trk.ph    = trk.prof[1] ? PH_TWELVE : PH_MATRIX;
          end else begin
            // intra-only profile 0 carries no color config
            trk.depth = DEPTH_8;
            trk.mtx   = MTX_BT470BG;
            trk.sx    = 1'b1;
            trk.sy    = 1'b1;
            trk.ph    = PH_REFRESH;
          end
        end
      end
      PH_TWELVE: begin
        trk.depth = b ? DEPTH_12 : DEPTH_10;
        trk.ph    = PH_MATRIX;
      end
      PH_MATRIX: begin
        if (collect(b, 3, v)) begin
          trk.sx = 1'b0;
          trk.sy = 1'b0;
          if (v[2:0] == CODE_MTX_IDENTITY) begin
            trk.mtx = MTX_IDENTITY;
            trk.rng = 1'b1;
            if (odd) trk.ph = PH_CC_RESERVED;
            else colour_done();
          end else begin
            trk.mtx = (v[2:0] == CODE_MTX_RESERVED) ? MTX_UNSPEC : v[2:0];
            trk.rng = 1'b0;
            trk.ph  = PH_RANGE;
          end
        end
      end
      PH_RANGE: begin
        trk.rng = b;
        if (odd) begin
          trk.ph = PH_SUBX;
        end else begin
          trk.sx = 1'b1;
          trk.sy = 1'b1;
          colour_done();
        end
      end
      PH_SUBX: begin
        trk.sx = b;
        trk.ph = PH_SUBY;
      end
      PH_SUBY: begin
        trk.sy = b;
        trk.ph = PH_CC_RESERVED;
      end
      PH_CC_RESERVED: colour_done();
      PH_REFRESH: begin
        if (collect(b, 8, v)) trk.ph = PH_WIDTH;
      end
      PH_WIDTH: begin
        if (collect(b, 16, v)) begin
          trk.w  = v;
          trk.ph = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (collect(b, 16, v)) begin
          trk.h  = v;
          trk.ph = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // feed one accepted byte, true when it closes a frame and hdr holds the result
  function automatic bit parse_frame_byte(input logic [7:0] b, input bit is_last,
                                          output header_beat_t hdr);
    hdr = '0;
    for (int i = 7; i >= 0; i--) begin
      if (trk.rejected || trk.ph == PH_DONE) break;
      parse_header_bit(b[i]);
    end
    if (!is_last) return 1'b0;
    if (!trk.rejected && trk.ph == PH_DONE) begin
      hdr.header_valid = 1'b1;
      hdr.profile      = trk.prof;
      hdr.sample_depth = trk.depth;
      hdr.is_key       = trk.key;
      hdr.sub_x        = trk.sx;
      hdr.sub_y        = trk.sy;
      hdr.matrix_kind  = trk.mtx;
      hdr.full_range   = trk.rng;
      hdr.frame_width  = {1'b0, trk.w} + 17'd1;
      hdr.frame_height = {1'b0, trk.h} + 17'd1;
    end
    clear_track();
    return 1'b1;
  endfunction

  function automatic void put_bits(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) hdr_bits.push_back(v[i]);
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed headers with random content; some noise, flipped bits, cut frames
  function automatic void compose_frame();
    int         kind;
    int         idx;
    int         nbytes;
    logic [1:0] prof;
    bit         key;
    bit         err;
    logic [2:0] code;
    logic [7:0] b;
    hdr_bits.delete();
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      nbytes = $urandom_range(1, 8);
      repeat (nbytes) frame_bytes.push_back(8'($urandom));
      return;
    end
    prof = 2'($urandom);
    key  = $urandom_range(0, 2) != 0;
    err  = 1'($urandom_range(0, 1));
    put_bits(16'(MARKER_CODE), 2);
    put_bits(16'(prof[0]), 1);
    put_bits(16'(prof[1]), 1);
    if (prof == 2'd3) put_bits(16'd0, 1);
    put_bits(16'd0, 1);
    put_bits(16'(!key), 1);
    put_bits(16'(key ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0)), 1);
    put_bits(16'(err), 1);
    if (!key) begin
      put_bits(16'($urandom_range(0, 9) != 0), 1);
      if (!err) put_bits(16'($urandom_range(0, 3)), 2);
    end
    put_bits(16'(SYNC_BYTE_0), 8);
    put_bits(16'(SYNC_BYTE_1), 8);
    put_bits(16'(SYNC_BYTE_2), 8);
    if (key || prof != 2'd0) begin
      if (prof[1]) put_bits(16'($urandom_range(0, 1)), 1);
      code = 3'($urandom);
      put_bits(16'(code), 3);
      if (code != CODE_MTX_IDENTITY) begin
        put_bits(16'($urandom_range(0, 1)), 1);
        if (prof[0]) put_bits(16'($urandom_range(0, 3)), 2);
      end
      if (prof[0]) put_bits(16'($urandom_range(0, 1)), 1);
    end
    if (!key) put_bits(16'($urandom_range(0, 255)), 8);
    put_bits(pick_size(), 16);
    put_bits(pick_size(), 16);
    if (kind < 23) begin
      idx = $urandom_range(0, hdr_bits.size() - 1);
      hdr_bits[idx] = !hdr_bits[idx];
    end
    while (hdr_bits.size() % 8 != 0) hdr_bits.push_back(1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2) * 8) hdr_bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i < hdr_bits.size(); i += 8) begin
      b = '0;
      for (int j = 0; j < 8; j++) b = {b[6:0], hdr_bits[i + j]};
      frame_bytes.push_back(b);
    end
    if (kind >= 23 && kind < 33) begin
      nbytes = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > nbytes) void'(frame_bytes.pop_back());
    end
  endfunction

  // offer one byte from a falling edge, return at the falling edge after it is taken
  task automatic push_byte(input logic [7:0] b, input bit is_last, input row_check_t chk);
    header_beat_t hdr;
    if (gaps_on && !hold_req && $urandom_range(0, 5) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_data  <= '{frame_byte: b, last_byte: is_last};
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    if (parse_frame_byte(b, is_last, hdr)) begin
      case (chk)
        CHK_REJECT: headers_due.push_back(HDR_REJECT);
        CHK_FULL:   headers_due.push_back(HDR_FULL);
        default:    headers_due.push_back(hdr);
      endcase
    end
    @(negedge clk);
  endtask

  task automatic check_header(input header_beat_t want, input header_beat_t got);
    if (got.header_valid !== want.header_valid) begin
      $error("header_valid: expected %0d, got %0d", want.header_valid, got.header_valid);
      mismatches++;
    end
    if (got.profile !== want.profile) begin
      $error("profile: expected %0d, got %0d", want.profile, got.profile);
      mismatches++;
    end
    if (got.sample_depth !== want.sample_depth) begin
      $error("sample_depth: expected %0d, got %0d", want.sample_depth, got.sample_depth);
      mismatches++;
    end
    if (got.is_key !== want.is_key) begin
      $error("is_key: expected %0d, got %0d", want.is_key, got.is_key);
      mismatches++;
    end
    if (got.sub_x !== want.sub_x) begin
      $error("sub_x: expected %0d, got %0d", want.sub_x, got.sub_x);
      mismatches++;
    end
    if (got.sub_y !== want.sub_y) begin
      $error("sub_y: expected %0d, got %0d", want.sub_y, got.sub_y);
      mismatches++;
    end
    if (got.matrix_kind !== want.matrix_kind) begin
      $error("matrix_kind: expected %0d, got %0d", want.matrix_kind, got.matrix_kind);
      mismatches++;
    end
    if (got.full_range !== want.full_range) begin
      $error("full_range: expected %0d, got %0d", want.full_range, got.full_range);
      mismatches++;
    end
    if (got.frame_width !== want.frame_width) begin
      $error("frame_width: expected %0d, got %0d", want.frame_width, got.frame_width);
      mismatches++;
    end
    if (got.frame_height !== want.frame_height) begin
      $error("frame_height: expected %0d, got %0d", want.frame_height, got.frame_height);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && hdr_valid && !hdr_stall) begin
      if (headers_due.size() == 0) begin
        $error("header beat with no frame pending");
        mismatches++;
      end else begin
        check_header(headers_due.pop_front(), hdr_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off to back the parser up
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hdr_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hdr_stall <= 1'b0;
        hold_req = 1'b0;
        @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        hdr_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        hdr_stall <= 1'b0;
        @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end
  end

  initial begin
    int sent;
    int wait_n;
    bit hold_done;
    sent      = 0;
    wait_n    = 0;
    hold_done = 1'b0;
    clear_track();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gaps_on = 1'b1;
    foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].is_last, dir_rows[i].chk);
    while (sent < RANDOM_BYTES) begin
      // no gaps at all near the end
      if (sent > RANDOM_BYTES * 85 / 100) gaps_on = 1'b0;
      else gaps_on = $urandom_range(0, 3) != 0;
      if (!hold_done && sent > HOLD_AT_BYTE) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      compose_frame();
      foreach (frame_bytes[i])
        push_byte(frame_bytes[i], i == frame_bytes.size() - 1, CHK_PRED);
      sent += frame_bytes.size();
    end
    frame_valid <= 1'b0;
    while (headers_due.size() != 0 && wait_n < 5000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (headers_due.size() != 0) begin
      $error("%0d header results never arrived", headers_due.size());
      mismatches++;
    end
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
